// ===== rtl/peer_address_table_unit_defines.svh =====
// Assertion macros shared by the peer address table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PEER_ADDRESS_TABLE_UNIT_DEFINES_SVH
`define PEER_ADDRESS_TABLE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define PAT_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("pat assertion failed");
`define PAT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("pat assertion failed");
`else
`define PAT_ASSERT_IMPL(label, clk, rst_n, a, b)
`define PAT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/pat_pkg.sv =====
// Types and constants for the peer address table.
// No dependencies.
package pat_pkg;
    localparam int IDENT_W = 384;
    localparam int IDX_W   = 16;

    localparam logic [2:0] FN_ROUND  = 3'd0;
    localparam logic [2:0] FN_PONG   = 3'd1;
    localparam logic [2:0] FN_ENUM   = 3'd2;
    localparam logic [2:0] FN_DELETE = 3'd3;
    localparam logic [2:0] FN_READ   = 3'd4;
    localparam logic [2:0] FN_FLUSH  = 3'd5;

    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_ROUND  = 3'd1;
    localparam logic [2:0] OP_PONG   = 3'd2;
    localparam logic [2:0] OP_ENUM   = 3'd3;
    localparam logic [2:0] OP_DELETE = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;
    localparam logic [2:0] OP_FLUSH  = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    localparam logic [1:0] REG_CACHE_EN  = 2'd0;
    localparam logic [1:0] REG_FLUSH_INT = 2'd1;

    localparam logic [15:0] MIN_PAYLOAD    = 16'd49;
    localparam logic [63:0] FLUSH_INT_INIT = 64'd60000000000;
    localparam logic [3:0]  LAST_WORD      = 4'd8;

    typedef struct packed {
        logic [2:0]         op;
        logic               short_pl;
        logic [47:0]        address;
        logic [63:0]        now;
        logic [IDENT_W-1:0] ident;
        logic [IDX_W-1:0]   idx;
    } cmd_t;
endpackage

// ===== rtl/peer_address_table_unit.sv =====
// Peer address table top level: configuration registers, front end and engine.
// Depends on pat_pkg, pat_front and pat_back.
//
// A command is taken when start is high and busy is low; up to two commands
// queue ahead of the engine. Each result beat is shown for one cycle with done
// high and must be captured then. Pong, delete and an enumeration reply that is
// neither short nor refused as full search the table linearly through one
// memory read port, one entry per cycle; a miss reads every entry, and a delete
// that moves an entry then copies the last entry into the freed slot. A read
// returns nine beats, the last with last high; other commands return one.
// No clearing pass is needed after reset.
module peer_address_table_unit
    import pat_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  func,
    input  logic [47:0] address,
    input  logic [63:0] now,
    input  logic [15:0] payload_length,
    input  logic [63:0] uuid_high,
    input  logic [63:0] uuid_low,
    input  logic [63:0] serial_word0,
    input  logic [63:0] serial_word1,
    input  logic [63:0] serial_word2,
    input  logic [63:0] serial_word3,
    input  logic [$clog2(MAX_ENTRIES)-1:0] entry_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output logic        done,
    output logic [2:0]  status,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] device_count,
    output logic        flush_due,
    output logic [3:0]  word_select,
    output logic [63:0] entry_word,
    output logic        last
);
    logic        cache_en_reg;
    logic [63:0] flush_int_reg;
    logic        q_valid, q_pop;
    cmd_t        q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_en_reg  <= 1'b0;
            flush_int_reg <= FLUSH_INT_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_CACHE_EN)
            begin
                cache_en_reg <= cfg_data[0];
            end
            else if (cfg_index == REG_FLUSH_INT)
            begin
                flush_int_reg <= cfg_data;
            end
        end
    end

    pat_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .address        (address),
        .now            (now),
        .payload_length (payload_length),
        .ident          ({serial_word3, serial_word2, serial_word1, serial_word0,
                          uuid_low, uuid_high}),
        .idx            (IDX_W'(entry_index)),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop)
    );

    pat_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .cache_en     (cache_en_reg),
        .flush_int    (flush_int_reg),
        .done         (done),
        .status       (status),
        .device_count (device_count),
        .flush_due    (flush_due),
        .word_select  (word_select),
        .entry_word   (entry_word),
        .last         (last)
    );
endmodule

// ===== rtl/pat_front.sv =====
// Front end: decodes commands and queues them for the table engine.
// Depends on pat_pkg.
`include "peer_address_table_unit_defines.svh"
module pat_front
    import pat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [2:0]   func,
    input  logic [47:0]  address,
    input  logic [63:0]  now,
    input  logic [15:0]  payload_length,
    input  logic [IDENT_W-1:0] ident,
    input  logic [IDX_W-1:0]   idx,
    output logic         q_valid,
    output cmd_t         q_cmd,
    input  logic         q_pop
);
    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in          = '0;
        cmd_in.address  = address;
        cmd_in.now      = now;
        cmd_in.ident    = ident;
        cmd_in.idx      = idx;
        cmd_in.short_pl = payload_length < MIN_PAYLOAD;
        unique case (func)
            FN_ROUND:  cmd_in.op = OP_ROUND;
            FN_PONG:   cmd_in.op = OP_PONG;
            FN_ENUM:   cmd_in.op = OP_ENUM;
            FN_DELETE: cmd_in.op = OP_DELETE;
            FN_READ:   cmd_in.op = OP_READ;
            FN_FLUSH:  cmd_in.op = OP_FLUSH;
            default:   cmd_in.op = OP_NOP;
        endcase
    end

    assign busy    = cnt_reg[1];
    assign push    = start && !busy;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    `PAT_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= 2'd2)
    `PAT_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, q_pop, cnt_reg != 2'd0)
    `PAT_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !q_pop, cnt_reg != 2'd0)
endmodule

// ===== rtl/pat_back.sv =====
// Table engine: linear search, entry stores and result sequencing.
// Depends on pat_pkg.
`include "peer_address_table_unit_defines.svh"
module pat_back
    import pat_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    input  logic        cache_en,
    input  logic [63:0] flush_int,
    output logic        done,
    output logic [2:0]  status,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] device_count,
    output logic        flush_due,
    output logic [3:0]  word_select,
    output logic [63:0] entry_word,
    output logic        last
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SEARCH  = 4'd1;
    localparam logic [3:0] S_UPDATE  = 4'd2;
    localparam logic [3:0] S_COPY_RD = 4'd3;
    localparam logic [3:0] S_COPY_WR = 4'd4;
    localparam logic [3:0] S_RD_ISS  = 4'd5;
    localparam logic [3:0] S_RD_OUT  = 4'd6;
    localparam logic [3:0] S_RESULT  = 4'd7;

    logic [47:0]        addr_mem  [MAX_ENTRIES];
    logic               onl_mem   [MAX_ENTRIES];
    logic [63:0]        rtt_mem   [MAX_ENTRIES];
    logic [63:0]        seen_mem  [MAX_ENTRIES];
    logic [IDENT_W-1:0] ident_mem [MAX_ENTRIES];

    logic [47:0]        addr_q;
    logic               onl_q;
    logic [63:0]        rtt_q, seen_q;
    logic [IDENT_W-1:0] ident_q;

    logic [3:0]  state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] si_reg, si_next;
    logic [CW-1:0] ci_reg, ci_next;
    logic        chk_reg, chk_next;
    logic [CW-1:0] slot_reg, slot_next;
    logic        found_reg, found_next;
    logic [2:0]  stat_reg, stat_next;
    logic [3:0]  w_reg, w_next;
    logic [63:0] round_reg, round_next;
    logic [63:0] nflush_reg, nflush_next;
    logic        dirty_reg, dirty_next;

    logic        done_reg, done_next;
    logic [2:0]  ostat_reg, ostat_next;
    logic        due_reg, due_next;
    logic [3:0]  ows_reg, ows_next;
    logic [63:0] oword_reg, oword_next;
    logic        olast_reg, olast_next;

    logic          rd_en;
    logic [IW-1:0] rd_idx;
    logic          we;
    logic          we_ident;
    logic [IW-1:0] wa;
    logic [47:0]   wd_addr;
    logic          wd_onl;
    logic [63:0]   wd_rtt, wd_seen;
    logic [IDENT_W-1:0] wd_ident;
    logic          due_now;
    logic [2:0]    wsel;
    logic [CW-1:0] ins_slot;

    assign due_now  = cache_en && dirty_reg && (cmd_reg.now >= nflush_reg);
    assign wsel     = 3'(w_reg - 4'd3);
    assign ins_slot = found_reg ? slot_reg : count_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        si_next     = si_reg;
        ci_next     = ci_reg;
        chk_next    = chk_reg;
        slot_next   = slot_reg;
        found_next  = found_reg;
        stat_next   = stat_reg;
        w_next      = w_reg;
        round_next  = round_reg;
        nflush_next = nflush_reg;
        dirty_next  = dirty_reg;
        done_next   = 1'b0;
        ostat_next  = ST_OK;
        due_next    = due_now;
        ows_next    = 4'd0;
        oword_next  = '0;
        olast_next  = 1'b1;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        rd_idx      = si_reg[IW-1:0];
        we          = 1'b0;
        we_ident    = 1'b0;
        wa          = slot_reg[IW-1:0];
        wd_addr     = cmd_reg.address;
        wd_onl      = 1'b1;
        wd_rtt      = cmd_reg.now - round_reg;
        wd_seen     = cmd_reg.now;
        wd_ident    = cmd_reg.ident;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    stat_next = ST_OK;
                    si_next   = '0;
                    chk_next  = 1'b0;
                    w_next    = 4'd0;
                    state_next = S_RESULT;
                    unique case (q_cmd.op)
                        OP_ROUND: round_next = q_cmd.now;
                        OP_FLUSH:
                        begin
                            if (dirty_reg)
                            begin
                                dirty_next  = 1'b0;
                                nflush_next = q_cmd.now + flush_int;
                            end
                        end
                        OP_READ:
                        begin
                            if (count_reg <= CW'(q_cmd.idx))
                            begin
                                stat_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                state_next = S_RD_ISS;
                            end
                        end
                        OP_ENUM:
                        begin
                            if (q_cmd.short_pl)
                            begin
                                stat_next = ST_SHORT;
                            end
                            else if (count_reg >= CW'(MAX_ENTRIES))
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        OP_PONG, OP_DELETE: state_next = S_SEARCH;
                        default: ;
                    endcase
                end
            end
            S_SEARCH:
            begin
                // one read issued per cycle, compared the cycle after
                rd_en = 1'b1;
                if (si_reg < count_reg)
                begin
                    si_next  = si_reg + 1'b1;
                    ci_next  = si_reg;
                    chk_next = 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                end
                if (chk_reg && addr_q == cmd_reg.address)
                begin
                    slot_next  = ci_reg;
                    found_next = 1'b1;
                    state_next = S_UPDATE;
                end
                else if (!chk_reg && si_reg >= count_reg)
                begin
                    found_next = 1'b0;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_RESULT;
                unique case (cmd_reg.op)
                    OP_PONG:
                    begin
                        if (found_reg)
                        begin
                            we = 1'b1;
                        end
                        else
                        begin
                            stat_next = ST_NOT_FOUND;
                        end
                    end
                    OP_ENUM:
                    begin
                        we         = 1'b1;
                        we_ident   = 1'b1;
                        wa         = ins_slot[IW-1:0];
                        dirty_next = 1'b1;
                        if (!found_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!found_reg)
                        begin
                            stat_next = ST_NOT_FOUND;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                            dirty_next = 1'b1;
                            if (slot_reg != count_reg - 1'b1)
                            begin
                                state_next = S_COPY_RD;
                            end
                        end
                    end
                endcase
            end
            S_COPY_RD:
            begin
                rd_en      = 1'b1;
                rd_idx     = count_reg[IW-1:0];
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                we         = 1'b1;
                we_ident   = 1'b1;
                wd_addr    = addr_q;
                wd_onl     = onl_q;
                wd_rtt     = rtt_q;
                wd_seen    = seen_q;
                wd_ident   = ident_q;
                state_next = S_RESULT;
            end
            S_RD_ISS:
            begin
                rd_en      = 1'b1;
                rd_idx     = cmd_reg.idx[IW-1:0];
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                done_next  = 1'b1;
                ows_next   = w_reg;
                olast_next = w_reg == LAST_WORD;
                unique case (w_reg)
                    4'd0:    oword_next = {15'd0, onl_q, addr_q};
                    4'd1:    oword_next = rtt_q;
                    4'd2:    oword_next = seen_q;
                    default: oword_next = ident_q[wsel*64 +: 64];
                endcase
                w_next = w_reg + 4'd1;
                if (w_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESULT:
            begin
                done_next  = 1'b1;
                ostat_next = stat_reg;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_q  <= addr_mem[rd_idx];
            onl_q   <= onl_mem[rd_idx];
            rtt_q   <= rtt_mem[rd_idx];
            seen_q  <= seen_mem[rd_idx];
            ident_q <= ident_mem[rd_idx];
        end
        if (we)
        begin
            onl_mem[wa]  <= wd_onl;
            rtt_mem[wa]  <= wd_rtt;
            seen_mem[wa] <= wd_seen;
        end
        if (we_ident)
        begin
            addr_mem[wa]  <= wd_addr;
            ident_mem[wa] <= wd_ident;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        si_reg    <= si_next;
        ci_reg    <= ci_next;
        slot_reg  <= slot_next;
        found_reg <= found_next;
        stat_reg  <= stat_next;
        w_reg     <= w_next;
        ostat_reg <= ostat_next;
        due_reg   <= due_next;
        ows_reg   <= ows_next;
        oword_reg <= oword_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            chk_reg    <= 1'b0;
            round_reg  <= '0;
            nflush_reg <= '0;
            dirty_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            chk_reg    <= chk_next;
            round_reg  <= round_next;
            nflush_reg <= nflush_next;
            dirty_reg  <= dirty_next;
            done_reg   <= done_next;
        end
    end

    assign done         = done_reg;
    assign status       = ostat_reg;
    assign device_count = count_reg;
    assign flush_due    = due_reg;
    assign word_select  = ows_reg;
    assign entry_word   = oword_reg;
    assign last         = olast_reg;

    `PAT_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_ENTRIES))
    `PAT_ASSERT_IMPL(a_word_range, clk, rst_n, done_reg, ows_reg <= LAST_WORD)
    `PAT_ASSERT_NEXT(a_result_beat, clk, rst_n, state_reg == S_RESULT, done_reg && olast_reg)
endmodule

// ===== tb/sv/peer_address_table_unit_test.sv =====
// Self-checking testbench for peer_address_table_unit: directed and random commands,
// predicted per beat by an in-bench table model. Depends on pat_pkg and the RTL.
module peer_address_table_unit_test;
    import pat_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 1024;
    localparam int CYCLE_LIMIT = 8000000;

    typedef struct {
        logic [2:0]  func;
        logic [47:0] address;
        logic [63:0] now;
        logic [15:0] plen;
        logic [63:0] ident [6];
        logic [9:0]  index;
    } peer_cmd_t;

    typedef struct {
        logic [2:0]  status;
        logic [10:0] count;
        logic        due;
        logic [3:0]  wsel;
        logic [63:0] word;
        logic        last;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  func = '0;
    logic [47:0] address = '0;
    logic [63:0] now = '0;
    logic [15:0] payload_length = '0;
    logic [63:0] uuid_high = '0, uuid_low = '0;
    logic [63:0] serial_word0 = '0, serial_word1 = '0, serial_word2 = '0, serial_word3 = '0;
    logic [9:0]  entry_index = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        done;
    logic [2:0]  status;
    logic [10:0] device_count;
    logic        flush_due;
    logic [3:0]  word_select;
    logic [63:0] entry_word;
    logic        last;

    peer_address_table_unit u_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow table
    logic [47:0] peer_addr [NSLOT];
    logic        peer_online [NSLOT];
    logic [63:0] peer_rtt [NSLOT];
    logic [63:0] peer_seen [NSLOT];
    logic [63:0] peer_ident [NSLOT][6];
    int          peer_count;
    logic [63:0] round_start, next_flush, flush_gap;
    logic        dirty, cache_on;

    beat_t       expected_beats [$];
    int          errors;
    int          cycles;
    int          burst_left;
    logic [63:0] clock_now;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int find_peer(input logic [47:0] a);
        for (int i = 0; i < peer_count; i++)
            if (peer_addr[i] == a)
                return i;
        return -1;
    endfunction

    function automatic void predict_beats(input peer_cmd_t c);
        int s;
        logic [2:0] st;
        logic due;
        beat_t b;
        bit rd;
        st = ST_OK;
        rd = 0;
        case (c.func)
            FN_ROUND: round_start = c.now;
            FN_PONG:
            begin
                s = find_peer(c.address);
                if (s < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    peer_online[s] = 1'b1;
                    peer_rtt[s] = c.now - round_start;
                    peer_seen[s] = c.now;
                end
            end
            FN_ENUM:
            begin
                if (c.plen < MIN_PAYLOAD)
                    st = ST_SHORT;
                else if (peer_count >= NSLOT)
                    st = ST_FULL;
                else
                begin
                    s = find_peer(c.address);
                    if (s < 0)
                        s = peer_count++;
                    peer_addr[s] = c.address;
                    for (int k = 0; k < 6; k++)
                        peer_ident[s][k] = c.ident[k];
                    peer_online[s] = 1'b1;
                    peer_rtt[s] = c.now - round_start;
                    peer_seen[s] = c.now;
                    dirty = 1'b1;
                end
            end
            FN_DELETE:
            begin
                s = find_peer(c.address);
                if (s < 0)
                    st = ST_NOT_FOUND;
                else
                begin
                    peer_count--;
                    if (s != peer_count)
                    begin
                        peer_addr[s] = peer_addr[peer_count];
                        peer_online[s] = peer_online[peer_count];
                        peer_rtt[s] = peer_rtt[peer_count];
                        peer_seen[s] = peer_seen[peer_count];
                        for (int k = 0; k < 6; k++)
                            peer_ident[s][k] = peer_ident[peer_count][k];
                    end
                    dirty = 1'b1;
                end
            end
            FN_READ:
            begin
                if (int'(c.index) >= peer_count)
                    st = ST_BAD_INDEX;
                else
                    rd = 1;
            end
            FN_FLUSH:
            begin
                if (dirty)
                begin
                    dirty = 1'b0;
                    next_flush = c.now + flush_gap;
                end
            end
            default: ;
        endcase
        due = cache_on && dirty && (c.now >= next_flush);
        b.status = st;
        b.count = 11'(peer_count);
        b.due = due;
        b.wsel = '0;
        b.word = '0;
        b.last = 1'b1;
        if (rd)
        begin
            for (int k = 0; k < 9; k++)
            begin
                b.wsel = 4'(k);
                b.last = (k == 8);
                case (k)
                    0: b.word = {15'b0, peer_online[c.index], peer_addr[c.index]};
                    1: b.word = peer_rtt[c.index];
                    2: b.word = peer_seen[c.index];
                    default: b.word = peer_ident[c.index][k-3];
                endcase
                expected_beats.push_back(b);
            end
        end
        else
            expected_beats.push_back(b);
    endfunction

    // result checker: each cycle with done high is one result beat
    always @(posedge clk)
    begin
        beat_t e;
        if (rst_n && done)
        begin
            if (expected_beats.size() == 0)
                report("result beat with nothing expected");
            else
            begin
                e = expected_beats.pop_front();
                if (status !== e.status)
                    report($sformatf("status %0d exp %0d", status, e.status));
                if (device_count !== e.count)
                    report($sformatf("device_count %0d exp %0d", device_count, e.count));
                if (flush_due !== e.due)
                    report($sformatf("flush_due %0b exp %0b", flush_due, e.due));
                if (word_select !== e.wsel)
                    report($sformatf("word_select %0d exp %0d", word_select, e.wsel));
                if (entry_word !== e.word)
                    report($sformatf("entry_word %h exp %h", entry_word, e.word));
                if (last !== e.last)
                    report($sformatf("last %0b exp %0b", last, e.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic peer_cmd_t blank_cmd(input logic [2:0] f, input logic [47:0] a);
        peer_cmd_t c;
        c.func = f;
        c.address = a;
        clock_now += $urandom_range(1, 5000);
        c.now = clock_now;
        c.plen = 16'(MIN_PAYLOAD);
        for (int k = 0; k < 6; k++)
            c.ident[k] = rand64();
        c.index = '0;
        return c;
    endfunction

    // drive one command and hold it until taken; start stays high afterward unless a paced burst ends
    task automatic send_cmd(input peer_cmd_t c, input bit paced);
        start <= 1'b1;
        func <= c.func;
        address <= c.address;
        now <= c.now;
        payload_length <= c.plen;
        uuid_high <= c.ident[0];
        uuid_low <= c.ident[1];
        serial_word0 <= c.ident[2];
        serial_word1 <= c.ident[3];
        serial_word2 <= c.ident[4];
        serial_word3 <= c.ident[5];
        entry_index <= c.index;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_beats(c);
        if (paced)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(0, 15);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        start <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_CACHE_EN)
            cache_on = val[0];
        else if (idx == REG_FLUSH_INT)
            flush_gap = val;
    endtask

    task automatic test_directed();
        peer_cmd_t c;
        write_reg(REG_CACHE_EN, 64'd1);
        write_reg(REG_FLUSH_INT, 64'd0);
        c = blank_cmd(FN_READ, '0);
        send_cmd(c, 0);                              // read on empty table
        c = blank_cmd(FN_PONG, 48'h123);
        send_cmd(c, 0);
        c = blank_cmd(FN_DELETE, 48'h123);
        send_cmd(c, 0);
        c = blank_cmd(FN_ENUM, '0);
        c.plen = 16'd48;
        send_cmd(c, 0);                              // one byte short
        c = blank_cmd(FN_ENUM, '0);
        c.plen = '0;
        send_cmd(c, 0);
        c = blank_cmd(FN_ENUM, '0);
        send_cmd(c, 0);
        c = blank_cmd(FN_ENUM, '1);
        c.plen = '1;
        for (int k = 0; k < 6; k++)
            c.ident[k] = '1;
        send_cmd(c, 0);
        c = blank_cmd(FN_ENUM, '0);                  // refresh existing entry
        for (int k = 0; k < 6; k++)
            c.ident[k] = '0;
        send_cmd(c, 0);
        c = blank_cmd(FN_ROUND, '0);
        c.now = '1;
        send_cmd(c, 0);
        c = blank_cmd(FN_PONG, '0);
        c.now = '0;                                  // round trip wraps
        send_cmd(c, 0);
        c = blank_cmd(FN_READ, '0);
        send_cmd(c, 0);
        c = blank_cmd(FN_READ, '0);
        c.index = 10'd1;
        send_cmd(c, 0);
        c = blank_cmd(FN_READ, '0);
        c.index = '1;
        send_cmd(c, 0);
        c = blank_cmd(FN_FLUSH, '0);
        send_cmd(c, 0);
        c = blank_cmd(FN_FLUSH, '0);                 // already clean
        send_cmd(c, 0);
        c = blank_cmd(3'd6, '0);
        send_cmd(c, 0);
        c = blank_cmd(3'd7, '1);
        send_cmd(c, 0);
        c = blank_cmd(FN_DELETE, '0);                // moves last entry down
        send_cmd(c, 0);
        c = blank_cmd(FN_READ, '0);
        send_cmd(c, 0);
        c = blank_cmd(FN_DELETE, '1);
        send_cmd(c, 0);
        c = blank_cmd(FN_FLUSH, '0);
        c.now = '1;                                  // flush at the largest time value
        send_cmd(c, 0);
    endtask

    task automatic test_random(input int n);
        peer_cmd_t c;
        int pick;
        logic [47:0] pool [8];
        for (int i = 0; i < 8; i++)
            pool[i] = {16'($urandom()), 32'($urandom())};
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0, 1: c = blank_cmd(FN_ROUND, (peer_count > 0) ?
                                    peer_addr[$urandom_range(0, peer_count - 1)] : pool[0]);
                2: c = blank_cmd(FN_ROUND, pool[$urandom_range(0, 7)]);
                default: c = blank_cmd(FN_ROUND, {16'($urandom()), 32'($urandom())});
            endcase
            if (pick < 8)
                c.func = FN_ROUND;
            else if (pick < 30)
                c.func = FN_PONG;
            else if (pick < 60)
                c.func = (peer_count > 40) ? FN_DELETE : FN_ENUM;
            else if (pick < 75)
                c.func = FN_DELETE;
            else if (pick < 92)
                c.func = FN_READ;
            else if (pick < 97)
                c.func = FN_FLUSH;
            else
                c.func = 3'($urandom_range(6, 7));
            c.plen = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 48))
                                                 : 16'($urandom_range(49, 65535));
            c.index = ($urandom_range(0, 4) == 0) ? 10'($urandom())
                                                  : 10'($urandom_range(0, peer_count + 1));
            if ($urandom_range(0, 19) == 0)
                c.now = rand64();
            send_cmd(c, 1);
        end
    endtask

    task automatic test_full_table();
        peer_cmd_t c;
        write_reg(REG_CACHE_EN, 64'd1);
        write_reg(REG_FLUSH_INT, 64'd1000);
        for (int i = peer_count; i < NSLOT; i++)
        begin
            c = blank_cmd(FN_ENUM, 48'h8000_0000_0000 + 48'(i));
            send_cmd(c, 0);
        end
        c = blank_cmd(FN_ENUM, 48'h7777_0000_0001);
        send_cmd(c, 0);                              // full
        c = blank_cmd(FN_ENUM, peer_addr[3]);
        send_cmd(c, 0);                              // full even when present
        c = blank_cmd(FN_ENUM, peer_addr[3]);
        c.plen = 16'd10;
        send_cmd(c, 0);                              // short wins over full
        c = blank_cmd(FN_READ, '0);
        c.index = '1;
        send_cmd(c, 0);
        c = blank_cmd(FN_PONG, peer_addr[NSLOT - 1]);
        send_cmd(c, 0);
        c = blank_cmd(FN_DELETE, peer_addr[0]);
        send_cmd(c, 0);
        c = blank_cmd(FN_READ, '0);
        send_cmd(c, 0);
        c = blank_cmd(FN_ENUM, 48'h7777_0000_0001);
        send_cmd(c, 0);
        c = blank_cmd(FN_FLUSH, '0);
        send_cmd(c, 0);
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        clock_now = 64'd1000;
        peer_count = 0;
        round_start = '0;
        next_flush = '0;
        dirty = 1'b0;
        cache_on = 1'b0;
        flush_gap = FLUSH_INT_INIT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(110);
        write_reg(REG_FLUSH_INT, '1);
        test_random(110);
        write_reg(REG_CACHE_EN, 64'd0);
        write_reg(REG_FLUSH_INT, rand64());
        test_random(110);
        write_reg(REG_CACHE_EN, 64'd1);
        write_reg(REG_FLUSH_INT, 64'($urandom_range(0, 20000)));
        test_random(110);
        test_full_table();
        start <= 1'b0;
        @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== peer_address_table_unit.f =====
+incdir+rtl
rtl/pat_pkg.sv
rtl/pat_front.sv
rtl/pat_back.sv
rtl/peer_address_table_unit.sv
tb/sv/peer_address_table_unit_test.sv
